// ===== rtl/lbl_pkg.sv =====
// shared constants, types and helper functions of the lca binary lifting table
package lbl_pkg;

	localparam int MAX_NODES   = 1023;
	localparam int LOG_LEVELS  = 10;
	localparam int NODE_W      = 10;
	localparam int DEPTH_MAX   = 1023;

	localparam int NODE_CNT    = (MAX_NODES < 1023) ? MAX_NODES + 1 : 1024;
	localparam int LEVEL_SLOTS = LOG_LEVELS + 1;
	localparam int JMP_CNT     = NODE_CNT * LEVEL_SLOTS;
	localparam int DEP_AW      = (NODE_CNT > 1) ? $clog2(NODE_CNT) : 1;
	localparam int JMP_AW      = (JMP_CNT > 1) ? $clog2(JMP_CNT) : 1;
	localparam int LVL_W       = (LEVEL_SLOTS > 1) ? $clog2(LEVEL_SLOTS) : 1;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [LVL_W-1:0]  lvl_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS_DEP,
		ST_INS_LVL,
		ST_Q_DA,
		ST_Q_DB,
		ST_Q_UP1,
		ST_Q_UP2,
		ST_Q_JA,
		ST_Q_JB,
		ST_Q_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic [DEP_AW-1:0] waddr;
		node_t             wdata;
		logic [DEP_AW-1:0] raddr;
	} dep_req_t;

	typedef struct packed {
		logic              we;
		logic [JMP_AW-1:0] waddr;
		node_t             wdata;
		logic [JMP_AW-1:0] raddr;
	} jmp_req_t;

	// ids beyond the table map to the null node
	function automatic node_t clamp_node(node_t n);
		return (int'(n) > MAX_NODES) ? '0 : n;
	endfunction

	function automatic logic [DEP_AW-1:0] dep_addr(node_t n);
		return DEP_AW'(n);
	endfunction

	// row per node, one entry per lifting level
	function automatic logic [JMP_AW-1:0] jmp_addr(node_t n, lvl_t l);
		return JMP_AW'(n) * JMP_AW'(LEVEL_SLOTS) + JMP_AW'(l);
	endfunction

endpackage

// ===== rtl/lbl_cmd_if.sv =====
// command channel: insert or query items
interface lbl_cmd_if import lbl_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  mode;
	node_t node_a;
	node_t node_b;

	modport source (output valid, output mode, output node_a, output node_b, input ready);
	modport sink   (input valid, input mode, input node_a, input node_b, output ready);
endinterface

// ===== rtl/lbl_res_if.sv =====
// result channel: lowest common ancestor items
interface lbl_res_if import lbl_pkg::*; ();
	logic  valid;
	logic  ready;
	node_t ancestor;

	modport source (output valid, output ancestor, input ready);
	modport sink   (input valid, input ancestor, output ready);
endinterface

// ===== rtl/lca_binary_lifting_table.sv =====
// top level: lowest common ancestor by binary lifting over a depth and a jump memory
//
// usage
// - cmd carries one item per handshake: mode 0 inserts node_a with parent node_b
//   (0 for a root), mode 1 asks for the lowest common ancestor of node_a and node_b
// - res returns one item per query, in order; inserts give no result
// - parents must be inserted before their children
// - insert: one depth read, then one jump memory read and write per lifting level,
//   before the next item can be taken
// - insert of the null node is dropped at once, the next item follows next cycle
// - query: the depth lift costs two dependent reads per level (jump entry, then
//   its depth), the joint lift two jump reads per level on the single jump read
//   port, then one read for the parent of the meeting point
// - after reset a clearing pass zeroes both memories, one jump entry per cycle;
//   cmd.ready stays low meanwhile
// - a finished result sits in an output register; while res is stalled the
//   engine still takes new items, and a second finished query waits for the slot
module lca_binary_lifting_table import lbl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lbl_cmd_if.sink   cmd,
	lbl_res_if.source res
);
	dep_req_t dep_req;
	jmp_req_t jmp_req;
	node_t    dep_rdata;
	node_t    jmp_rdata;

	logic  done_valid;
	logic  done_ready;
	node_t done_node;

	logic  out_valid_q;
	node_t ancestor_q;

	// walk sequencer
	lbl_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.dep_req    (dep_req),
		.dep_rdata  (dep_rdata),
		.jmp_req    (jmp_req),
		.jmp_rdata  (jmp_rdata),
		.done_valid (done_valid),
		.done_ready (done_ready),
		.done_node  (done_node)
	);

	// depth per node
	lbl_ram #(
		.WIDTH (NODE_W),
		.DEPTH (NODE_CNT)
	) u_dep_ram (
		.clk   (clk),
		.we    (dep_req.we),
		.waddr (dep_req.waddr),
		.wdata (dep_req.wdata),
		.raddr (dep_req.raddr),
		.rdata (dep_rdata)
	);

	// ancestor at distance 2^level, row per node
	lbl_ram #(
		.WIDTH (NODE_W),
		.DEPTH (JMP_CNT)
	) u_jmp_ram (
		.clk   (clk),
		.we    (jmp_req.we),
		.waddr (jmp_req.waddr),
		.wdata (jmp_req.wdata),
		.raddr (jmp_req.raddr),
		.rdata (jmp_rdata)
	);

	// output slot frees when empty or when the consumer takes the item
	assign done_ready = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_valid && done_ready) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_valid && done_ready) begin
			ancestor_q <= done_node;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.ancestor = ancestor_q;
endmodule

// ===== rtl/lbl_ram.sv =====
// generic simple dual port ram, registered read, read-first on collision
module lbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/lbl_engine.sv =====
// sequencer for clear, insert and query walks over the depth and jump memories
module lbl_engine import lbl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	lbl_cmd_if.sink  cmd,
	output dep_req_t dep_req,
	input  node_t    dep_rdata,
	output jmp_req_t jmp_req,
	input  node_t    jmp_rdata,
	output logic     done_valid,
	input  logic     done_ready,
	output node_t    done_node
);
	state_t            state_q, state_d;
	logic [JMP_AW-1:0] clr_q, clr_d;
	node_t             a_q, a_d, b_q, b_d;
	node_t             mid_q, mid_d;
	node_t             tgt_q, tgt_d;
	node_t             da_q, da_d;
	node_t             up_q, up_d;
	node_t             ua_q, ua_d;
	node_t             res_q, res_d;
	lvl_t              lvl_q, lvl_d;
	logic              byp_hit_q;
	node_t             byp_data_q;

	node_t jr;
	node_t na, nb;
	node_t a_new, b_new;

	assign jr        = byp_hit_q ? byp_data_q : jmp_rdata;
	assign na        = clamp_node(cmd.node_a);
	assign nb        = clamp_node(cmd.node_b);
	assign done_node = res_q;

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		a_d        = a_q;
		b_d        = b_q;
		mid_d      = mid_q;
		tgt_d      = tgt_q;
		da_d       = da_q;
		up_d       = up_q;
		ua_d       = ua_q;
		res_d      = res_q;
		lvl_d      = lvl_q;
		a_new      = a_q;
		b_new      = b_q;
		dep_req    = '0;
		jmp_req    = '0;
		cmd.ready  = 1'b0;
		done_valid = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				jmp_req.we    = 1'b1;
				jmp_req.waddr = clr_q;
				dep_req.we    = (int'(clr_q) < NODE_CNT);
				dep_req.waddr = DEP_AW'(clr_q);
				if (clr_q == JMP_AW'(JMP_CNT - 1)) begin
					state_d = ST_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					a_d = na;
					b_d = nb;
					if (cmd.mode == MODE_QUERY) begin
						dep_req.raddr = dep_addr(na);
						state_d       = ST_Q_DA;
					end else if (na != '0) begin
						// level 0 is the parent itself
						dep_req.raddr = dep_addr(nb);
						jmp_req.we    = 1'b1;
						jmp_req.waddr = jmp_addr(na, '0);
						jmp_req.wdata = nb;
						mid_d         = nb;
						lvl_d         = LVL_W'(1);
						state_d       = ST_INS_DEP;
					end
				end
			end
			ST_INS_DEP: begin
				dep_req.we    = 1'b1;
				dep_req.waddr = dep_addr(a_q);
				dep_req.wdata = (dep_rdata == NODE_W'(DEPTH_MAX)) ? dep_rdata
				                                                 : dep_rdata + 1'b1;
				if (LOG_LEVELS == 0) begin
					state_d = ST_IDLE;
				end else begin
					jmp_req.raddr = jmp_addr(mid_q, LVL_W'(lvl_q - 1'b1));
					state_d       = ST_INS_LVL;
				end
			end
			ST_INS_LVL: begin
				jmp_req.we    = 1'b1;
				jmp_req.waddr = jmp_addr(a_q, lvl_q);
				jmp_req.wdata = jr;
				if (lvl_q == LVL_W'(LOG_LEVELS)) begin
					state_d = ST_IDLE;
				end else begin
					mid_d         = jr;
					lvl_d         = lvl_q + 1'b1;
					jmp_req.raddr = jmp_addr(jr, lvl_q);
				end
			end
			ST_Q_DA: begin
				da_d          = dep_rdata;
				dep_req.raddr = dep_addr(b_q);
				state_d       = ST_Q_DB;
			end
			ST_Q_DB: begin
				// deeper node goes to a
				if (da_q < dep_rdata) begin
					a_d   = b_q;
					b_d   = a_q;
					tgt_d = da_q;
					a_new = b_q;
				end else begin
					tgt_d = dep_rdata;
					a_new = a_q;
				end
				lvl_d         = LVL_W'(LOG_LEVELS);
				jmp_req.raddr = jmp_addr(a_new, LVL_W'(LOG_LEVELS));
				state_d       = ST_Q_UP1;
			end
			ST_Q_UP1: begin
				up_d          = jr;
				dep_req.raddr = dep_addr(jr);
				state_d       = ST_Q_UP2;
			end
			ST_Q_UP2: begin
				a_new = (dep_rdata >= tgt_q) ? up_q : a_q;
				a_d   = a_new;
				if (lvl_q == '0) begin
					if (a_new == b_q) begin
						res_d   = a_new;
						state_d = ST_DONE;
					end else begin
						lvl_d         = LVL_W'(LOG_LEVELS);
						jmp_req.raddr = jmp_addr(a_new, LVL_W'(LOG_LEVELS));
						state_d       = ST_Q_JA;
					end
				end else begin
					lvl_d         = lvl_q - 1'b1;
					jmp_req.raddr = jmp_addr(a_new, LVL_W'(lvl_q - 1'b1));
					state_d       = ST_Q_UP1;
				end
			end
			ST_Q_JA: begin
				ua_d          = jr;
				jmp_req.raddr = jmp_addr(b_q, lvl_q);
				state_d       = ST_Q_JB;
			end
			ST_Q_JB: begin
				if (ua_q != jr) begin
					a_new = ua_q;
					b_new = jr;
				end
				a_d = a_new;
				b_d = b_new;
				if (lvl_q == '0) begin
					jmp_req.raddr = jmp_addr(a_new, '0);
					state_d       = ST_Q_FIN;
				end else begin
					lvl_d         = lvl_q - 1'b1;
					jmp_req.raddr = jmp_addr(a_new, LVL_W'(lvl_q - 1'b1));
					state_d       = ST_Q_JA;
				end
			end
			ST_Q_FIN: begin
				res_d   = jr;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				done_valid = 1'b1;
				if (done_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			byp_hit_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_q     <= clr_d;
			// read of an entry written in the same cycle takes the new value
			byp_hit_q <= jmp_req.we && (jmp_req.waddr == jmp_req.raddr);
		end
	end

	always_ff @(posedge clk) begin
		a_q        <= a_d;
		b_q        <= b_d;
		mid_q      <= mid_d;
		tgt_q      <= tgt_d;
		da_q       <= da_d;
		up_q       <= up_d;
		ua_q       <= ua_d;
		res_q      <= res_d;
		lvl_q      <= lvl_d;
		byp_data_q <= jmp_req.wdata;
	end
endmodule

// ===== rtl/lbl_checker.sv =====
// port level checks for the lca binary lifting table, bound to the top level
module lbl_checker import lbl_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  cmd_valid,
	input logic  cmd_ready,
	input logic  cmd_mode,
	input logic  res_valid,
	input logic  res_ready,
	input node_t res_ancestor
);
	logic [1:0] pend_q;
	logic       q_acc;
	logic       r_acc;

	assign q_acc = cmd_valid && cmd_ready && (cmd_mode == MODE_QUERY);
	assign r_acc = res_valid && res_ready;

	// queries taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (q_acc && !r_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (r_acc && !q_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_ancestor))
		else $error("result changed while stalled");

	a_res_owed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 2'd0)
		else $error("result without an open query");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two queries open");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_acc |=> !cmd_ready)
		else $error("new item taken right after a query");
endmodule

bind lca_binary_lifting_table lbl_checker u_lbl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.cmd_mode     (cmd.mode),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_ancestor (res.ancestor)
);
